[design/wtc_pkg.sv]
// ----------------------------------------------------------------------------
// wtc_pkg: shared types and constants for the windowed thermostat
// Field widths, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package wtc_pkg;

  localparam int SAMPLE_W   = 12;  // converter code, quarter degrees
  localparam int DEG_W      = 10;  // whole degrees (sample >> 2)
  localparam int SUM_W      = 14;  // window sum of whole degrees
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int WINDOW_LEN_DEF      = 10;
  localparam int BAND_DEG            = 3;
  localparam int OVERHEAT_MARGIN_DEG = 10;

  localparam int SETPOINT_RST = 0;
  localparam int AMBIENT_RST  = 25;

  // status codes
  localparam logic [STATUS_W-1:0] ST_HEATING    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HEATED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERHEATED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COOLING    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COOLED     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 1'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_qdeg;
    logic                enabled;
  } in_item_t;

  typedef struct packed {
    logic                heater_on;
    logic [STATUS_W-1:0] status;
    logic [SUM_W-1:0]    window_sum_deg;
  } out_item_t;

endpackage

[design/wtc_ram.sv]
// ----------------------------------------------------------------------------
// wtc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/windowed_thermostat_with_status_top.sv]
// ----------------------------------------------------------------------------
// windowed_thermostat_with_status_top: moving-average bang-bang thermostat
// Keeps a window of whole-degree samples in a ring-buffer RAM, maintains a
// running sum and derives the heater drive and a band status per item.
// ----------------------------------------------------------------------------
// Path: input accept, stage 1 register, then the result register on out_valid.
// Throughput: 1 item per cycle while out_stall is low, set by the read-modify-write
//   of the window RAM (read oldest at accept, overwrite it as the item advances).
// Reset (rst_n low, synchronous): window entries read as zero through per-entry
//   valid bits, sum and status clear, setpoint 0 and ambient 25 are loaded.
//   No clearing pass; items are accepted on the first cycle after reset.
// ----------------------------------------------------------------------------
module windowed_thermostat_with_status_top #(
  parameter int WINDOW_LEN = wtc_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wtc_pkg::in_item_t                in_data,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output wtc_pkg::out_item_t               out_data,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [wtc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [wtc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEG_W  = wtc_pkg::DEG_W;
  localparam int SUM_W  = wtc_pkg::SUM_W;
  localparam int PTR_W  = $clog2(WINDOW_LEN);
  // signed width of the scaled limits, (2**DEG_W + band) * window length
  localparam int SCL_W  = $clog2(((2 ** DEG_W) + wtc_pkg::BAND_DEG) * WINDOW_LEN) + 1;

  localparam logic signed [SCL_W-1:0] BAND_S = SCL_W'(wtc_pkg::BAND_DEG);
  localparam logic signed [SCL_W-1:0] WIN_S  = SCL_W'(WINDOW_LEN);
  localparam logic signed [SCL_W-1:0] LO_RST =
    SCL_W'((wtc_pkg::SETPOINT_RST - wtc_pkg::BAND_DEG) * WINDOW_LEN);
  localparam logic signed [SCL_W-1:0] HI_RST =
    SCL_W'((wtc_pkg::SETPOINT_RST + wtc_pkg::BAND_DEG) * WINDOW_LEN);
  localparam logic signed [SCL_W-1:0] AMB_RST =
    SCL_W'(wtc_pkg::AMBIENT_RST * WINDOW_LEN);
  localparam logic [DEG_W:0] OVR_OFS =
    (DEG_W + 1)'(wtc_pkg::BAND_DEG + wtc_pkg::OVERHEAT_MARGIN_DEG);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(WINDOW_LEN * ((2 ** DEG_W) - 1));

  // --------------------------------------------------------------------------
  // Configuration: hold setpoint and the window-scaled limits in registers,
  // so the per-item compare needs no multiply.
  // --------------------------------------------------------------------------
  logic [DEG_W-1:0]        sp_r, sp_nxt;
  logic signed [SCL_W-1:0] lo_n_r, lo_n_nxt;
  logic signed [SCL_W-1:0] hi_n_r, hi_n_nxt;
  logic signed [SCL_W-1:0] amb_n_r, amb_n_nxt;
  logic signed [SCL_W-1:0] cfg_ext;

  always_comb begin
    sp_nxt    = sp_r;
    lo_n_nxt  = lo_n_r;
    hi_n_nxt  = hi_n_r;
    amb_n_nxt = amb_n_r;
    cfg_ext   = $signed({{(SCL_W - DEG_W){1'b0}}, cfg_wdata});
    if (cfg_we) begin
      unique case (cfg_addr)
        wtc_pkg::CFG_SETPOINT: begin
          sp_nxt   = cfg_wdata;
          lo_n_nxt = (cfg_ext - BAND_S) * WIN_S;
          hi_n_nxt = (cfg_ext + BAND_S) * WIN_S;
        end
        wtc_pkg::CFG_AMBIENT: begin
          amb_n_nxt = cfg_ext * WIN_S;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= DEG_W'(wtc_pkg::SETPOINT_RST);
      lo_n_r  <= LO_RST;
      hi_n_r  <= HI_RST;
      amb_n_r <= AMB_RST;
    end else begin
      sp_r    <= sp_nxt;
      lo_n_r  <= lo_n_nxt;
      hi_n_r  <= hi_n_nxt;
      amb_n_r <= amb_n_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: accepted item waits here while the RAM returns the oldest entry
  // at the write pointer. The same slot is overwritten when the item advances.
  // --------------------------------------------------------------------------
  logic             in_fire;
  logic             s1_adv;
  logic             s1_valid_r, s1_valid_nxt;
  logic [DEG_W-1:0] s1_deg_r;
  logic             s1_en_r;
  logic [PTR_W-1:0] s1_addr_r;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [WINDOW_LEN-1:0] wvld_r, wvld_nxt;

  // advance into the output register when it is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);
  assign wp_nxt = !in_fire ? wp_r : ((wp_r == PTR_LAST) ? '0 : wp_r + 1'b1);

  always_comb begin
    wvld_nxt = wvld_r;
    if (s1_adv) begin
      wvld_nxt[s1_addr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wp_r       <= '0;
      wvld_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      wp_r       <= wp_nxt;
      wvld_r     <= wvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_deg_r  <= in_data.sample_qdeg[wtc_pkg::SAMPLE_W-1:2];
      s1_en_r   <= in_data.enabled;
      s1_addr_r <= wp_r;
    end
  end

  // --------------------------------------------------------------------------
  // Window RAM. Read the slot of a new item; re-read the waiting item's slot
  // while it holds so the read data stays put. A read and a write meet on one
  // slot only when the waiting item leaves with no new item behind it, and
  // that read data is never used; otherwise consecutive items use
  // consecutive slots.
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] ram_raddr;
  logic [DEG_W-1:0] ram_rdata;
  logic [DEG_W-1:0] old_deg;

  assign ram_raddr = in_fire ? wp_r : s1_addr_r;

  wtc_ram #(
    .WIDTH (DEG_W),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (s1_deg_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written slots count as zero
  assign old_deg = wvld_r[s1_addr_r] ? ram_rdata : '0;

  // --------------------------------------------------------------------------
  // Stage 2: update the running sum, apply the band rules, load the result.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [wtc_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic signed [SCL_W-1:0]       sum_s;
  logic                          ovr_hot;
  logic                          heater;

  assign sum_nxt = s1_adv ? (sum_r - SUM_W'(old_deg) + SUM_W'(s1_deg_r)) : sum_r;
  assign sum_s   = $signed({{(SCL_W - SUM_W){1'b0}}, sum_nxt});
  assign ovr_hot = {1'b0, s1_deg_r} > ({1'b0, sp_r} + OVR_OFS);
  assign heater  = s1_en_r && (s1_deg_r <= sp_r);

  // later rules win; with no match the status holds
  always_comb begin
    status_nxt = status_r;
    if (s1_adv) begin
      if (s1_en_r) begin
        if (sum_s < lo_n_r) begin
          status_nxt = wtc_pkg::ST_HEATING;
        end
        if (sum_s > lo_n_r && sum_s < hi_n_r) begin
          status_nxt = wtc_pkg::ST_HEATED;
        end
        if (ovr_hot && sum_s > hi_n_r) begin
          status_nxt = wtc_pkg::ST_OVERHEATED;
        end
      end else begin
        if (sum_s > amb_n_r && sum_s < hi_n_r) begin
          status_nxt = wtc_pkg::ST_COOLING;
        end
        if (sum_s < amb_n_r) begin
          status_nxt = wtc_pkg::ST_COOLED;
        end
      end
    end
  end

  logic               out_valid_r, out_valid_nxt;
  wtc_pkg::out_item_t out_data_r;

  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      status_r    <= wtc_pkg::ST_HEATING;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.heater_on      <= heater;
      out_data_r.status         <= status_nxt;
      out_data_r.window_sum_deg <= sum_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage 1 advanced but no result is held");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX)
    else $error("running sum above window maximum");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PTR_LAST)
    else $error("write pointer out of window");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(sum_r)))
    else $error("waiting item lost or sum changed while held");

endmodule
